/* src/box_blur_3x3_border_mean_macros.svh */
// Assertion macros for the box blur checker.
`ifndef BOX_BLUR_3X3_BORDER_MEAN_MACROS_SVH
`define BOX_BLUR_3X3_BORDER_MEAN_MACROS_SVH

// same-cycle implication, off while in reset
`define BB3_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off while in reset
`define BB3_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also holds across reset
`define BB3_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* src/bb3_pkg.sv */
`default_nettype none

package bb3_pkg;

  localparam int PIX_W     = 8;
  localparam int POS_W     = 11;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int SUM_W     = 12;   // up to 9 * 255
  localparam int CSUM_W    = 10;   // up to 3 * 255

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

  localparam int W_RESET = 640;
  localparam int H_RESET = 480;

  // result lanes per pixel and output queue
  localparam int LANES    = 4;
  localparam int OQ_DEPTH = 8;
  localparam int OQ_AW    = 3;
  localparam int OQ_CW    = 4;

  // out_tdata layout
  localparam int OUT_DATA_W  = 32;
  localparam int OUT_ROW_LSB = PIX_W;
  localparam int OUT_COL_LSB = PIX_W + POS_W;
  localparam int OUT_PAD_W   = OUT_DATA_W - PIX_W - 2 * POS_W;

  // reciprocals, Q16, exact for sums in range
  localparam logic [13:0] RECIP6 = 14'd10923;
  localparam logic [13:0] RECIP9 = 14'd7282;

  typedef enum logic [1:0] {
    DIV4,
    DIV6,
    DIV9
  } div_t;

  typedef struct packed {
    logic [PIX_W-1:0] blurred;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
    logic             frame_end;
  } res_t;

  typedef struct packed {
    logic [LANES-1:0] mask;
    res_t [LANES-1:0] lane;
  } push_t;

  function automatic logic [PIX_W-1:0] bb3_mean(input logic [SUM_W-1:0] sum,
                                                input div_t d);
    logic [25:0]      prod;
    logic [PIX_W-1:0] mean;
    prod = '0;
    case (d)
      DIV4: begin
        mean = sum[PIX_W+1:2];
      end
      DIV6: begin
        prod = 26'(sum) * 26'(RECIP6);
        mean = prod[23:16];
      end
      DIV9: begin
        prod = 26'(sum) * 26'(RECIP9);
        mean = prod[23:16];
      end
      default: begin
        mean = sum[PIX_W+1:2];
      end
    endcase
    return mean;
  endfunction

  function automatic div_t bb3_div_sel(input logic cols3, input logic rows3);
    div_t d;
    if (cols3 && rows3) begin
      d = DIV9;
    end else if (cols3 || rows3) begin
      d = DIV6;
    end else begin
      d = DIV4;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

/* src/bb3_ram.sv */
`default_nettype none

module bb3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* src/bb3_kernel.sv */
`default_nettype none

// 3x3 window, border-aware sums and means for the four candidate results.
module bb3_kernel import bb3_pkg::*; #(
  parameter int CW = 11,
  parameter int RW = 11
) (
  input  wire logic             clk,
  input  wire logic             adv,
  input  wire logic [PIX_W-1:0] pix,
  input  wire logic [PIX_W-1:0] above,
  input  wire logic [PIX_W-1:0] two_above,
  input  wire logic [RW-1:0]    row,
  input  wire logic [CW-1:0]    col,
  input  wire logic [CW-1:0]    wlast,
  input  wire logic [RW-1:0]    hlast,
  output push_t                 push_o
);

  // win0 = column c-2, win1 = column c-1; index 0 is the oldest row
  logic [PIX_W-1:0]  win0_r [3];
  logic [PIX_W-1:0]  win1_r [3];
  logic [PIX_W-1:0]  colv   [3][3];
  logic [CSUM_W-1:0] full   [3];
  logic [CSUM_W-1:0] low    [3];
  logic [CSUM_W-1:0] col_a  [3];
  logic [SUM_W-1:0]  s0, s1, s2, s3;
  logic              rows3, cols3, r_ge1, c_ge1, c_last, r_last;
  logic [LANES-1:0]  emit, last;
  logic [RW-1:0]     rm1;
  logic [CW-1:0]     cm1;
  logic [POS_W-1:0]  o_rm1, o_r, o_cm1, o_c;

  always_ff @(posedge clk) begin
    if (adv) begin
      win0_r    <= win1_r;
      win1_r[0] <= two_above;
      win1_r[1] <= above;
      win1_r[2] <= pix;
    end
  end

  always_comb begin
    colv[0] = win0_r;
    colv[1] = win1_r;
    colv[2] = '{two_above, above, pix};
    rows3   = {1'b0, row} >= (RW + 1)'(2);
    cols3   = {1'b0, col} >= (CW + 1)'(2);
    for (int k = 0; k < 3; k++) begin
      low[k]   = CSUM_W'(colv[k][1]) + CSUM_W'(colv[k][2]);
      full[k]  = low[k] + CSUM_W'(colv[k][0]);
      col_a[k] = rows3 ? full[k] : low[k];
    end
    s1 = SUM_W'(col_a[1]) + SUM_W'(col_a[2]);
    s0 = s1 + (cols3 ? SUM_W'(col_a[0]) : '0);
    s3 = SUM_W'(low[1]) + SUM_W'(low[2]);
    s2 = s3 + (cols3 ? SUM_W'(low[0]) : '0);
  end

  always_comb begin
    r_ge1  = row != '0;
    c_ge1  = col != '0;
    c_last = col == wlast;
    r_last = row == hlast;
    emit[0] = r_ge1 & c_ge1;
    emit[1] = r_ge1 & c_last;
    emit[2] = r_ge1 & r_last & c_ge1;
    emit[3] = r_ge1 & r_last & c_last;
    // tag the final emitted lane
    for (int k = 0; k < LANES; k++) begin
      last[k] = emit[k];
      for (int j = k + 1; j < LANES; j++) begin
        last[k] = last[k] & ~emit[j];
      end
    end
    rm1   = row - RW'(1);
    cm1   = col - CW'(1);
    o_rm1 = POS_W'(rm1);
    o_r   = POS_W'(row);
    o_cm1 = POS_W'(cm1);
    o_c   = POS_W'(col);
  end

  always_comb begin
    push_o.mask    = emit;
    push_o.lane[0] = '{blurred: bb3_mean(s0, bb3_div_sel(cols3, rows3)),
                       row: o_rm1, col: o_cm1, last: last[0], frame_end: 1'b0};
    push_o.lane[1] = '{blurred: bb3_mean(s1, bb3_div_sel(1'b0, rows3)),
                       row: o_rm1, col: o_c, last: last[1], frame_end: 1'b0};
    push_o.lane[2] = '{blurred: bb3_mean(s2, bb3_div_sel(cols3, 1'b0)),
                       row: o_r, col: o_cm1, last: last[2], frame_end: 1'b0};
    push_o.lane[3] = '{blurred: bb3_mean(s3, DIV4),
                       row: o_r, col: o_c, last: last[3], frame_end: 1'b1};
  end

endmodule

`default_nettype wire

/* src/bb3_ofifo.sv */
`default_nettype none

// Result queue: up to LANES writes per cycle, one read.
module bb3_ofifo import bb3_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire push_t push_i,
  output logic       room,
  output logic       rd_valid,
  input  wire logic  rd_ready,
  output res_t       rd_data
);

  res_t             mem [OQ_DEPTH];
  logic [OQ_AW-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [OQ_CW-1:0] cnt_r, cnt_nxt;
  logic [OQ_AW-1:0] offs [LANES];
  logic [OQ_CW-1:0] npush;
  logic             pop;

  always_comb begin
    npush = '0;
    for (int k = 0; k < LANES; k++) begin
      offs[k] = OQ_AW'(npush);
      if (push_i.mask[k]) begin
        npush = npush + OQ_CW'(1);
      end
    end
    if (!push) begin
      npush = '0;
    end
    pop      = rd_valid & rd_ready;
    wptr_nxt = wptr_r + OQ_AW'(npush);
    rptr_nxt = rptr_r + OQ_AW'(pop);
    cnt_nxt  = cnt_r + npush - OQ_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < LANES; k++) begin
      if (push && push_i.mask[k]) begin
        mem[wptr_r + offs[k]] <= push_i.lane[k];
      end
    end
  end

  assign room     = cnt_r <= OQ_CW'(OQ_DEPTH - LANES);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem[rptr_r];

endmodule

`default_nettype wire

/* src/box_blur_3x3_border_mean.sv */
`default_nettype none

// Channel  Dir  Payload (low bit up)                                  Transfer
// in_      in   tdata[7:0] pixel_in                                   tvalid & tready
// out_     out  tdata blurred[7:0] out_row[18:8] out_col[29:19] 0s;   tvalid & tready
//               tlast last_of_run; tuser frame_end
// cfg_     in   cfg_index (0 width, 1 height), cfg_data[11:0]         cfg_valid & cfg_ready
//
// One pixel per cycle while the queue has room; a pixel's results enter the queue
// as it leaves the window stage (line buffer read at the transfer, window math in
// that stage). In the bottom row each pixel past column 0 yields two results, four
// at the row end, so the single output port sets the pace; row-end bursts sit in
// the 8-entry queue; in_tready drops while a pixel waits and it holds more than four.
// Reset (rst_n low, synchronous) clears counters, queue and pipeline valid;
// the line buffers need no clearing pass. A width or height write restarts the frame.
module box_blur_3x3_border_mean import bb3_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [PIX_W-1:0]      in_tdata,    // [7:0] pixel_in
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [OUT_DATA_W-1:0] out_tdata,   // blurred, out_row, out_col, zero pad
  output logic                       out_tlast,   // last_of_run
  output logic                       out_tuser,   // frame_end
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WSW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam int HSW = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;
  localparam int W_RST = (W_RESET > MAX_WIDTH) ? MAX_WIDTH : W_RESET;
  localparam int H_RST = (H_RESET > MAX_HEIGHT) ? MAX_HEIGHT : H_RESET;

  // frame geometry, kept as last column / last row index after clamping
  logic [CW-1:0]    wlast_r, wlast_nxt;
  logic [RW-1:0]    hlast_r, hlast_nxt;
  logic [WSW-1:0]   wreq, wclamp;
  logic [HSW-1:0]   hreq, hclamp;
  logic             cfg_we;

  // position of the next pixel to transfer
  logic [CW-1:0]    col_r, col_nxt;
  logic [RW-1:0]    row_r, row_nxt;

  // pixel in the window stage; line buffer data lines up with it
  logic             s1_valid_r, s1_valid_nxt;
  logic [PIX_W-1:0] s1_pix_r;
  logic [CW-1:0]    s1_col_r;
  logic [RW-1:0]    s1_row_r;
  logic [PIX_W-1:0] above, two_above;

  logic             in_acc, s1_adv, room;
  push_t            push;
  res_t             head;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;
  assign in_acc    = in_tvalid & in_tready;
  assign s1_adv    = s1_valid_r & room;
  assign in_tready = ~s1_valid_r | s1_adv;

  // sizes below 2 read as 2, above the buffer size as the buffer size
  always_comb begin
    wreq = WSW'(cfg_data);
    hreq = HSW'(cfg_data);
    if (wreq < WSW'(2)) begin
      wclamp = WSW'(2);
    end else if (wreq > WSW'(MAX_WIDTH)) begin
      wclamp = WSW'(MAX_WIDTH);
    end else begin
      wclamp = wreq;
    end
    if (hreq < HSW'(2)) begin
      hclamp = HSW'(2);
    end else if (hreq > HSW'(MAX_HEIGHT)) begin
      hclamp = HSW'(MAX_HEIGHT);
    end else begin
      hclamp = hreq;
    end
    wlast_nxt = wlast_r;
    hlast_nxt = hlast_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  wlast_nxt = CW'(wclamp - WSW'(1));
        REG_HEIGHT: hlast_nxt = RW'(hclamp - HSW'(1));
        default: begin
        end
      endcase
    end
  end

  // raster position; a write to a listed register restarts the frame
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT)) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_acc) begin
      if (col_r == wlast_r) begin
        col_nxt = '0;
        row_nxt = (row_r == hlast_r) ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlast_r    <= CW'(W_RST - 1);
      hlast_r    <= RW'(H_RST - 1);
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      wlast_r    <= wlast_nxt;
      hlast_r    <= hlast_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r <= in_tdata;
      s1_col_r <= col_r;
      s1_row_r <= row_r;
    end
  end

  // line buffers: read on transfer, written when the pixel leaves the window stage.
  // Within a frame, consecutive pixels never share a column: no read/write collision.
  bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_above (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r),
    .wdata (s1_pix_r),
    .re    (in_acc),
    .raddr (col_r),
    .rdata (above)
  );

  bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_two_above (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r),
    .wdata (above),
    .re    (in_acc),
    .raddr (col_r),
    .rdata (two_above)
  );

  bb3_kernel #(.CW(CW), .RW(RW)) u_kernel (
    .clk       (clk),
    .adv       (s1_adv),
    .pix       (s1_pix_r),
    .above     (above),
    .two_above (two_above),
    .row       (s1_row_r),
    .col       (s1_col_r),
    .wlast     (wlast_r),
    .hlast     (hlast_r),
    .push_o    (push)
  );

  bb3_ofifo u_ofifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (s1_adv),
    .push_i   (push),
    .room     (room),
    .rd_valid (out_tvalid),
    .rd_ready (out_tready),
    .rd_data  (head)
  );

  assign out_tdata = {{OUT_PAD_W{1'b0}}, head.col, head.row, head.blurred};
  assign out_tlast = head.last;
  assign out_tuser = head.frame_end;

endmodule

`default_nettype wire

/* src/bb3_checker.sv */
`default_nettype none

`include "box_blur_3x3_border_mean_macros.svh"

module bb3_checker import bb3_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic                  out_tlast,
  input wire logic                  out_tuser
);

  // queue comes up empty
  `BB3_ASSERT_RST(a_rst_empty, !rst_n, !out_tvalid, "result offered right after reset")

  // a stalled result stays put
  `BB3_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

  // bottom-right result is always the final one of its pixel
  `BB3_ASSERT_IMP(a_fe_last, out_tvalid && out_tuser, out_tlast, "frame end without tlast")

  // frames have at least two rows, so frame end is never on row 0
  `BB3_ASSERT_IMP(a_fe_row, out_tvalid && out_tuser, out_tdata[OUT_ROW_LSB +: POS_W] != '0, "frame end on row 0")

  // input only backs up behind pending results
  `BB3_ASSERT_IMP(a_stall_cause, !in_tready, out_tvalid, "input stalled with empty queue")

endmodule

bind box_blur_3x3_border_mean bb3_checker u_bb3_checker (.*);

`default_nettype wire
